### rtl/mexp_pkg.sv
// Package for the modular exponentiator: sequencer and multiplier state
// types and the control/status structs shared between them. No dependencies.
package mexp_pkg;

    localparam int FIELD_WIDTH = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_BASE_W,
        ST_STEP,
        ST_MUL,
        ST_MUL_W,
        ST_SQR,
        ST_SQR_W,
        ST_OUT
    } mexp_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_MUL,
        MM_RED,
        MM_DONE
    } mm_state_t;

    typedef struct packed {
        logic start;
    } mm_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

### rtl/mexp_modmul.sv
// Shared modular multiplier: a registered full product, then bit-serial restoring
// reduction that shifts in the low half one bit per cycle. Depends on mexp_pkg.
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mm_ctrl_t                 ctrl,
    input  logic [OPERAND_WIDTH-1:0] op_a,
    input  logic [OPERAND_WIDTH-1:0] op_b,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output mm_stat_t                 stat,
    output logic [OPERAND_WIDTH-1:0] result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    mm_state_t         state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]      op_a_reg, op_a_next;
    logic [W-1:0]      op_b_reg, op_b_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      low_reg, low_next;
    logic [2*W-1:0]    product;
    logic [W:0]        n_ext;
    logic [W:0]        shifted;

    // a zero modulus stands for 2^W
    assign n_ext   = {(modulus == '0), modulus};
    assign product = op_a_reg * op_b_reg;
    assign shifted = {rem_reg, low_reg[W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_a_next  = op_a_reg;
        op_b_next  = op_b_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        unique case (state_reg)
            MM_IDLE: begin
                if (ctrl.start) begin
                    op_a_next  = op_a;
                    op_b_next  = op_b;
                    state_next = MM_MUL;
                end
            end
            MM_MUL: begin
                rem_next   = product[2*W-1:W];
                low_next   = product[W-1:0];
                cnt_next   = '0;
                state_next = MM_RED;
            end
            MM_RED: begin
                if (shifted >= n_ext) begin
                    rem_next = W'(shifted - n_ext);
                end else begin
                    rem_next = shifted[W-1:0];
                end
                low_next = {low_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = MM_DONE;
                end
            end
            MM_DONE: begin
                state_next = MM_IDLE;
            end
            default: begin
                state_next = MM_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != MM_IDLE);
    assign stat.done = (state_reg == MM_DONE);
    assign result    = rem_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> state_reg == MM_IDLE)
        else $error("multiplier started while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> !stat.done && !stat.busy)
        else $error("done not a single pulse");

    a_red_follows_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MM_MUL) |=> (state_reg == MM_RED) && (cnt_reg == '0))
        else $error("reduction did not start after product");

endmodule

### rtl/modular_exponentiator.sv
// Modular exponentiator, right-to-left binary square and multiply.
// Takes one word at a time: s_tready is high only while the sequencer is idle.
// Every modular multiply runs on one shared unit and passes through a start,
// a product step, OPERAND_WIDTH reduction steps and a handoff.
// An item with a nonzero exponent takes one base reduction plus one multiply
// per set exponent bit and one squaring per bit below the highest set bit,
// with a decision step per exponent bit up to the highest set bit; an
// exponent of zero goes straight to the output state and returns 1.
// A modulus of zero means 2^OPERAND_WIDTH. Write the modulus only while the
// block is idle.
// Depends on mexp_pkg and mexp_modmul.
module modular_exponentiator
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [FIELD_WIDTH-1:0] cfg_wdata,    // modulus
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,      // [31:0] base_value, [63:32] power
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata       // [31:0] residue
);

    localparam int W = OPERAND_WIDTH;

    mexp_state_t          state_reg, state_next;
    logic [W-1:0]         modulus_reg;
    logic [W-1:0]         sq_reg, sq_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         bits_reg, bits_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;
    mm_ctrl_t             mm_ctrl;
    mm_stat_t             mm_stat;
    logic [W-1:0]         mm_a, mm_b, mm_result;
    logic                 s_accept;
    logic                 out_free;

    mexp_modmul #(
        .OPERAND_WIDTH(W)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mm_ctrl),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus_reg),
        .stat    (mm_stat),
        .result  (mm_result)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            modulus_reg  <= W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                modulus_reg <= cfg_wdata[W-1:0];
            end
        end
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        bits_reg    <= bits_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        sq_next       = sq_reg;
        acc_next      = acc_reg;
        bits_next     = bits_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mm_ctrl.start = 1'b0;
        mm_a          = sq_reg;
        mm_b          = sq_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sq_next   = s_tdata[W-1:0];
                    bits_next = s_tdata[32 +: W];
                    acc_next  = W'(1);
                    if (s_tdata[32 +: W] == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                mm_ctrl.start = 1'b1;
                mm_b          = W'(1);
                state_next    = ST_BASE_W;
            end
            ST_BASE_W: begin
                if (mm_stat.done) begin
                    sq_next    = mm_result;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = bits_reg[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL: begin
                mm_ctrl.start = 1'b1;
                mm_a          = acc_reg;
                state_next    = ST_MUL_W;
            end
            ST_MUL_W: begin
                if (mm_stat.done) begin
                    acc_next = mm_result;
                    // skip the final squaring once no higher bit is set
                    if (bits_reg[W-1:1] == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                mm_ctrl.start = 1'b1;
                state_next    = ST_SQR_W;
            end
            ST_SQR_W: begin
                if (mm_stat.done) begin
                    sq_next    = mm_result;
                    bits_next  = {1'b0, bits_reg[W-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_next  = 32'(acc_reg);
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mm_stat.busy)
        else $error("multiplier busy while sequencer idle");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && out_free |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result not loaded into output register");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == ST_BASE_W) || (state_reg == ST_MUL_W)
                         || (state_reg == ST_SQR_W))
        else $error("multiplier result with no sequencer waiting");

endmodule
